>>> hdl/trm_pkg.sv
// types, constants and helpers shared by the two-ray midpoint pipeline
`timescale 1ns / 1ps
package trm_pkg;

  localparam int DirW   = 16;
  localparam int PosW   = 20;
  localparam int InW    = 216;
  localparam int OutW   = 80;
  localparam int DivQW  = 47;
  localparam int DivMW  = 37;
  localparam int NumMW  = 43;
  localparam int DivNW  = 66;
  localparam int ParW   = 47;
  localparam int GW     = 27;
  localparam int SqW    = 52;
  localparam int SqrtN  = 26;
  localparam int GapW   = 20;

  localparam logic [DivQW-1:0] ParPosMax = {1'b0, {(DivQW-1){1'b1}}};
  localparam logic [DivQW-1:0] ParNegMax = {1'b1, {(DivQW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][DirW-1:0] d1;
    logic [2:0][PosW-1:0] p1;
    logic [2:0][DirW-1:0] d2;
    logic [2:0][PosW-1:0] p2;
  } rays_t;

  typedef struct packed {
    logic [DivMW-1:0] rem;
    logic [DivQW-1:0] quo;
    logic [DivQW-1:0] nlo;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    logic             par;
    logic [DivMW-1:0] m;
    div_lane_t        r;
    div_lane_t        s;
    rays_t            rays;
  } div_stage_t;

  typedef struct packed {
    logic                 par;
    logic [2:0][PosW-1:0] mid;
    logic [SqW-1:0]       v;
    logic [SqW-1:0]       res;
  } sqrt_stage_t;

  // one restoring division step
  function automatic div_lane_t div_step(div_lane_t l, logic [DivMW-1:0] m);
    logic [DivMW:0] t;
    logic           ge;
    div_lane_t      o;
    t     = {l.rem, l.nlo[DivQW-1]};
    ge    = (t >= {1'b0, m});
    o     = l;
    o.rem = ge ? DivMW'(t - {1'b0, m}) : DivMW'(t);
    o.quo = {l.quo[DivQW-2:0], ge};
    o.nlo = {l.nlo[DivQW-2:0], 1'b0};
    return o;
  endfunction

  // signed ray parameter from quotient magnitude, saturated
  function automatic logic [ParW-1:0] param_sel(div_lane_t l);
    logic [DivQW-1:0] mg;
    if (l.neg) begin
      mg = (l.ovf || (l.quo > ParNegMax)) ? ParNegMax : l.quo;
      return ParW'(~mg + 1'b1);
    end
    mg = (l.ovf || (l.quo > ParPosMax)) ? ParPosMax : l.quo;
    return ParW'(mg);
  endfunction

endpackage

>>> hdl/two_ray_midpoint_top.sv
// two_ray_midpoint_top: pipelined midpoint triangulation of two 3-d rays
//
// channel  dir  fields (lsb first)
// s_axis   in   tdata: first_dir_x/y/z, first_origin_x/y/z, second_dir_x/y/z,
//                      second_origin_x/y/z
// m_axis   out  tdata: mid_x, mid_y, mid_z, gap_length; tuser: parallel_flag
//
// one transaction per cycle while the output is not stalled
// the pipeline holds the two 47-stage parameter dividers and the 26-stage square root
// reset clears only the valid bits
// a stalled output freezes the whole pipeline, nothing is lost or repeated
`timescale 1ns / 1ps
module two_ray_midpoint_top
  import trm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // first_dir_x/y/z, first_origin_x/y/z, second_dir_x/y/z, second_origin_x/y/z
  input  logic [InW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // mid_x, mid_y, mid_z, gap_length
  output logic [OutW-1:0]  m_axis_tdata,
  // parallel_flag
  output logic [0:0]       m_axis_tuser
);

  logic adv;
  logic out_vld_q;

  assign adv           = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: unpack, w = p1 - p2
  logic               s1_vld_q;
  rays_t              rays_c, s1_rays_q;
  logic signed [20:0] s1_w_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rays_c.d1[i] = s_axis_tdata[16*i +: 16];
      rays_c.p1[i] = s_axis_tdata[48 + 20*i +: 20];
      rays_c.d2[i] = s_axis_tdata[108 + 16*i +: 16];
      rays_c.p2[i] = s_axis_tdata[156 + 20*i +: 20];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rays_q <= rays_c;
      for (int i = 0; i < 3; i++) begin
        s1_w_q[i] <= 21'($signed(rays_c.p1[i])) - 21'($signed(rays_c.p2[i]));
      end
    end
  end

  // stage 2: elementwise products
  logic               s2_vld_q;
  rays_t              s2_rays_q;
  logic signed [31:0] s2_uu_q [3];
  logic signed [31:0] s2_uv_q [3];
  logic signed [31:0] s2_vv_q [3];
  logic signed [36:0] s2_wu_q [3];
  logic signed [36:0] s2_wv_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rays_q <= s1_rays_q;
      for (int i = 0; i < 3; i++) begin
        s2_uu_q[i] <= $signed(s1_rays_q.d1[i]) * $signed(s1_rays_q.d1[i]);
        s2_uv_q[i] <= $signed(s1_rays_q.d1[i]) * $signed(s1_rays_q.d2[i]);
        s2_vv_q[i] <= $signed(s1_rays_q.d2[i]) * $signed(s1_rays_q.d2[i]);
        s2_wu_q[i] <= s1_w_q[i] * $signed(s1_rays_q.d1[i]);
        s2_wv_q[i] <= s1_w_q[i] * $signed(s1_rays_q.d2[i]);
      end
    end
  end

  // stage 3: dot products, scaled down
  logic               s3_vld_q;
  rays_t              s3_rays_q;
  logic signed [33:0] a_sum, b_sum, c_sum;
  logic signed [38:0] d_sum, e_sum;
  logic signed [19:0] s3_a_q, s3_b_q, s3_c_q;
  logic signed [24:0] s3_d_q, s3_e_q;

  always_comb begin
    a_sum = 34'(s2_uu_q[0]) + 34'(s2_uu_q[1]) + 34'(s2_uu_q[2]);
    b_sum = 34'(s2_uv_q[0]) + 34'(s2_uv_q[1]) + 34'(s2_uv_q[2]);
    c_sum = 34'(s2_vv_q[0]) + 34'(s2_vv_q[1]) + 34'(s2_vv_q[2]);
    d_sum = 39'(s2_wu_q[0]) + 39'(s2_wu_q[1]) + 39'(s2_wu_q[2]);
    e_sum = 39'(s2_wv_q[0]) + 39'(s2_wv_q[1]) + 39'(s2_wv_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_rays_q <= s2_rays_q;
      s3_a_q    <= 20'(a_sum >>> 14);
      s3_b_q    <= 20'(b_sum >>> 14);
      s3_c_q    <= 20'(c_sum >>> 14);
      s3_d_q    <= 25'(d_sum >>> 14);
      s3_e_q    <= 25'(e_sum >>> 14);
    end
  end

  // stage 4: products for determinant and numerators
  logic               s4_vld_q;
  rays_t              s4_rays_q;
  logic signed [39:0] s4_ac_q, s4_bb_q;
  logic signed [44:0] s4_be_q, s4_cd_q, s4_ae_q, s4_bd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_rays_q <= s3_rays_q;
      s4_ac_q   <= s3_a_q * s3_c_q;
      s4_bb_q   <= s3_b_q * s3_b_q;
      s4_be_q   <= 45'(s3_b_q) * 45'(s3_e_q);
      s4_cd_q   <= 45'(s3_c_q) * 45'(s3_d_q);
      s4_ae_q   <= 45'(s3_a_q) * 45'(s3_e_q);
      s4_bd_q   <= 45'(s3_b_q) * 45'(s3_d_q);
    end
  end

  // stage 5: determinant and numerators
  logic               s5_vld_q;
  rays_t              s5_rays_q;
  logic signed [40:0] s5_det_q;
  logic signed [45:0] s5_nr_q, s5_ns_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_rays_q <= s4_rays_q;
      s5_det_q  <= 41'(s4_ac_q) - 41'(s4_bb_q);
      s5_nr_q   <= 46'(s4_be_q) - 46'(s4_cd_q);
      s5_ns_q   <= 46'(s4_ae_q) - 46'(s4_bd_q);
    end
  end

  // stage 6: magnitudes, signs and parallel flag
  logic             s6_vld_q;
  rays_t            s6_rays_q;
  logic [DivMW-1:0] s6_m_q;
  logic [NumMW-1:0] s6_anr_q, s6_ans_q;
  logic             s6_negr_q, s6_negs_q, s6_par_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_rays_q <= s5_rays_q;
      s6_m_q    <= DivMW'(s5_det_q[40] ? -s5_det_q : s5_det_q);
      s6_anr_q  <= NumMW'(s5_nr_q[45] ? -s5_nr_q : s5_nr_q);
      s6_ans_q  <= NumMW'(s5_ns_q[45] ? -s5_ns_q : s5_ns_q);
      s6_negr_q <= s5_nr_q[45] ^ s5_det_q[40];
      s6_negs_q <= s5_ns_q[45] ^ s5_det_q[40];
      s6_par_q  <= (s5_det_q == '0);
    end
  end

  // stage 7 and on: restoring dividers, one quotient bit per stage
  logic [DivNW-1:0] nr_c, ns_c;
  div_stage_t       div0_c;
  div_stage_t       div_q   [DivQW+1];
  logic             div_vld_q [DivQW+1];

  always_comb begin
    nr_c = (DivNW'(s6_anr_q) << 22) + DivNW'(s6_m_q >> 1);
    ns_c = (DivNW'(s6_ans_q) << 22) + DivNW'(s6_m_q >> 1);
    div0_c.par   = s6_par_q;
    div0_c.m     = s6_m_q;
    div0_c.rays  = s6_rays_q;
    div0_c.r.rem = DivMW'(nr_c >> DivQW);
    div0_c.r.quo = '0;
    div0_c.r.nlo = nr_c[DivQW-1:0];
    div0_c.r.neg = s6_negr_q;
    div0_c.r.ovf = (nr_c >> DivQW) >= DivNW'(s6_m_q);
    div0_c.s.rem = DivMW'(ns_c >> DivQW);
    div0_c.s.quo = '0;
    div0_c.s.nlo = ns_c[DivQW-1:0];
    div0_c.s.neg = s6_negs_q;
    div0_c.s.ovf = (ns_c >> DivQW) >= DivNW'(s6_m_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div0_c;
    end
  end

  for (genvar k = 0; k < DivQW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k+1].par  <= div_q[k].par;
        div_q[k+1].m    <= div_q[k].m;
        div_q[k+1].rays <= div_q[k].rays;
        div_q[k+1].r    <= div_step(div_q[k].r, div_q[k].m);
        div_q[k+1].s    <= div_step(div_q[k].s, div_q[k].m);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        div_vld_q[k+1] <= div_vld_q[k];
      end
    end
  end

  // ray parameters, zero for parallel rays
  logic                 ps_vld_q, ps_par_q;
  rays_t                ps_rays_q;
  logic signed [ParW-1:0] ps_r_q, ps_s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ps_rays_q <= div_q[DivQW].rays;
      ps_par_q  <= div_q[DivQW].par;
      ps_r_q    <= div_q[DivQW].par ? '0 : $signed(param_sel(div_q[DivQW].r));
      ps_s_q    <= div_q[DivQW].par ? '0 : $signed(param_sel(div_q[DivQW].s));
    end
  end

  // parameter times direction
  logic               pm_vld_q, pm_par_q;
  rays_t              pm_rays_q;
  logic signed [62:0] pm_ru_q [3];
  logic signed [62:0] pm_sv_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm_rays_q <= ps_rays_q;
      pm_par_q  <= ps_par_q;
      for (int i = 0; i < 3; i++) begin
        pm_ru_q[i] <= 63'(ps_r_q) * 63'($signed(ps_rays_q.d1[i]));
        pm_sv_q[i] <= 63'(ps_s_q) * 63'($signed(ps_rays_q.d2[i]));
      end
    end
  end

  // closest points in 2^-22 units
  logic               cp_vld_q, cp_par_q;
  logic signed [63:0] cp_q1_q [3];
  logic signed [63:0] cp_q2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cp_par_q <= pm_par_q;
      for (int i = 0; i < 3; i++) begin
        cp_q1_q[i] <= (64'($signed(pm_rays_q.p1[i])) <<< 22) + 64'(pm_ru_q[i]);
        cp_q2_q[i] <= (64'($signed(pm_rays_q.p2[i])) <<< 22) + 64'(pm_sv_q[i]);
      end
    end
  end

  // midpoint and per-axis gap, rounded
  logic               mr_vld_q, mr_par_q;
  logic signed [64:0] mid_sum [3];
  logic signed [64:0] gap_dif [3];
  logic signed [41:0] mr_mid_q [3];
  logic signed [46:0] mr_g_q   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid_sum[i] = 65'(cp_q1_q[i]) + 65'(cp_q2_q[i]) + 65'sh400000;
      gap_dif[i] = 65'(cp_q1_q[i]) - 65'(cp_q2_q[i]) + 65'sh20000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_par_q <= cp_par_q;
      for (int i = 0; i < 3; i++) begin
        mr_mid_q[i] <= 42'(mid_sum[i] >>> 23);
        mr_g_q[i]   <= 47'(gap_dif[i] >>> 18);
      end
    end
  end

  // clamp
  logic                  cl_vld_q, cl_par_q;
  logic [2:0][PosW-1:0]  cl_mid_q;
  logic signed [GW-1:0]  cl_g_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cl_par_q <= mr_par_q;
      for (int i = 0; i < 3; i++) begin
        if (mr_mid_q[i] > 42'sd524287) begin
          cl_mid_q[i] <= 20'h7FFFF;
        end else if (mr_mid_q[i] < -42'sd524288) begin
          cl_mid_q[i] <= 20'h80000;
        end else begin
          cl_mid_q[i] <= mr_mid_q[i][19:0];
        end
        if (mr_g_q[i] > 47'sd33554432) begin
          cl_g_q[i] <= 27'sd33554432;
        end else if (mr_g_q[i] < -47'sd33554432) begin
          cl_g_q[i] <= -27'sd33554432;
        end else begin
          cl_g_q[i] <= mr_g_q[i][GW-1:0];
        end
      end
    end
  end

  // squares
  logic                  sq_vld_q, sq_par_q;
  logic [2:0][PosW-1:0]  sq_mid_q;
  logic signed [53:0]    g_sq [3];
  logic [50:0]           sq_g2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_sq[i] = 54'(cl_g_q[i]) * 54'(cl_g_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_par_q <= cl_par_q;
      sq_mid_q <= cl_mid_q;
      for (int i = 0; i < 3; i++) begin
        sq_g2_q[i] <= g_sq[i][50:0];
      end
    end
  end

  // integer square root, one result bit per stage
  sqrt_stage_t rt_q     [SqrtN+1];
  logic        rt_vld_q [SqrtN+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_q[0].par <= sq_par_q;
      rt_q[0].mid <= sq_mid_q;
      rt_q[0].v   <= SqW'(sq_g2_q[0]) + SqW'(sq_g2_q[1]) + SqW'(sq_g2_q[2]);
      rt_q[0].res <= '0;
    end
  end

  for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
    localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqrtN - 1 - k));
    logic [SqW-1:0] trial;
    assign trial = rt_q[k].res + Bit;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_q[k+1].par <= rt_q[k].par;
        rt_q[k+1].mid <= rt_q[k].mid;
        if (rt_q[k].v >= trial) begin
          rt_q[k+1].v   <= rt_q[k].v - trial;
          rt_q[k+1].res <= (rt_q[k].res >> 1) + Bit;
        end else begin
          rt_q[k+1].v   <= rt_q[k].v;
          rt_q[k+1].res <= rt_q[k].res >> 1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end
  end

  // output register
  logic [22:0]          gap_rnd;
  logic [GapW-1:0]      out_gap_q;
  logic [2:0][PosW-1:0] out_mid_q;
  logic                 out_par_q;

  assign gap_rnd = 23'((27'(rt_q[SqrtN].res[SqrtN-1:0]) + 27'd8) >> 4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_mid_q <= rt_q[SqrtN].mid;
      out_par_q <= rt_q[SqrtN].par;
      out_gap_q <= (gap_rnd > 23'(20'hFFFFF)) ? 20'hFFFFF : gap_rnd[GapW-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      s3_vld_q     <= 1'b0;
      s4_vld_q     <= 1'b0;
      s5_vld_q     <= 1'b0;
      s6_vld_q     <= 1'b0;
      div_vld_q[0] <= 1'b0;
      ps_vld_q     <= 1'b0;
      pm_vld_q     <= 1'b0;
      cp_vld_q     <= 1'b0;
      mr_vld_q     <= 1'b0;
      cl_vld_q     <= 1'b0;
      sq_vld_q     <= 1'b0;
      rt_vld_q[0]  <= 1'b0;
      out_vld_q    <= 1'b0;
    end else if (adv) begin
      s1_vld_q     <= s_axis_tvalid;
      s2_vld_q     <= s1_vld_q;
      s3_vld_q     <= s2_vld_q;
      s4_vld_q     <= s3_vld_q;
      s5_vld_q     <= s4_vld_q;
      s6_vld_q     <= s5_vld_q;
      div_vld_q[0] <= s6_vld_q;
      ps_vld_q     <= div_vld_q[DivQW];
      pm_vld_q     <= ps_vld_q;
      cp_vld_q     <= pm_vld_q;
      mr_vld_q     <= cp_vld_q;
      cl_vld_q     <= mr_vld_q;
      sq_vld_q     <= cl_vld_q;
      rt_vld_q[0]  <= sq_vld_q;
      out_vld_q    <= rt_vld_q[SqrtN];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_gap_q, out_mid_q[2], out_mid_q[1], out_mid_q[0]};
  assign m_axis_tuser  = out_par_q;

endmodule

>>> hdl/trm_checker.sv
// port-level checker for two_ray_midpoint_top and its bind
`timescale 1ns / 1ps
module trm_checker
  import trm_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic [0:0]      m_axis_tuser
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // input side only stalls when a result is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("tready does not follow output stall");

  // no result right after reset
  a_reset: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // parallel flag known on a valid transaction
  a_no_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown(m_axis_tuser))
    else $error("parallel flag unknown on a valid transaction");

endmodule

bind two_ray_midpoint_top trm_checker u_trm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/two_ray_midpoint_top_tb.sv
// testbench for two_ray_midpoint_top: directed table and random ray pairs
`timescale 1ns / 1ps
module two_ray_midpoint_top_tb;
  import trm_pkg::*;

  typedef struct {
    logic signed [DirW-1:0] d1 [3];
    logic signed [PosW-1:0] p1 [3];
    logic signed [DirW-1:0] d2 [3];
    logic signed [PosW-1:0] p2 [3];
  } ray_pair_t;

  typedef struct packed {
    logic [PosW-1:0] mid_x;
    logic [PosW-1:0] mid_y;
    logic [PosW-1:0] mid_z;
    logic [GapW-1:0] gap;
    logic            par;
  } midpoint_t;

  typedef struct {
    ray_pair_t rays;
    bit        known;
    midpoint_t res;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;
  logic [0:0]       m_axis_tuser;

  midpoint_t pending_midpoints[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  two_ray_midpoint_top dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  function automatic logic [InW-1:0] pack_rays(ray_pair_t r);
    logic [InW-1:0] v;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      v[i*DirW +: DirW]                 = r.d1[i];
      v[3*DirW + i*PosW +: PosW]        = r.p1[i];
      v[3*DirW + 3*PosW + i*DirW +: DirW] = r.d2[i];
      v[6*DirW + 3*PosW + i*PosW +: PosW] = r.p2[i];
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint ray_param(longint num, longint den);
    longint unsigned n, m, q;
    longint          lim;
    lim = 64'sd1 <<< 46;
    n = (num < 0 ? -num : num) << 22;
    m = den < 0 ? -den : den;
    q = (n + m / 2) / m;
    if ((num < 0) != (den < 0)) begin
      if (q > lim) q = lim;
      return -longint'(q);
    end
    if (q > lim - 1) q = lim - 1;
    return longint'(q);
  endfunction

  function automatic midpoint_t triangulate(ray_pair_t r);
    longint          u[3], v[3], o1[3], o2[3], w[3], pm[3];
    longint          a, b, c, dd, e, ca, cb, cc, cd, ce, det, rp, sp, q1, q2, m, g;
    longint unsigned sumsq, t, gap;
    midpoint_t       res;
    a = 0; b = 0; c = 0; dd = 0; e = 0; rp = 0; sp = 0; sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = r.d1[i]; v[i] = r.d2[i]; o1[i] = r.p1[i]; o2[i] = r.p2[i];
      w[i] = o1[i] - o2[i];
    end
    for (int i = 0; i < 3; i++) begin
      a += u[i] * u[i]; b += u[i] * v[i]; c += v[i] * v[i];
      dd += w[i] * u[i]; e += w[i] * v[i];
    end
    ca = a >>> 14; cb = b >>> 14; cc = c >>> 14; cd = dd >>> 14; ce = e >>> 14;
    det = ca * cc - cb * cb;
    if (det != 0) begin
      rp = ray_param(cb * ce - cc * cd, det);
      sp = ray_param(ca * ce - cb * cd, det);
    end
    for (int i = 0; i < 3; i++) begin
      q1 = (o1[i] <<< 22) + rp * u[i];
      q2 = (o2[i] <<< 22) + sp * v[i];
      m = (q1 + q2 + (64'sd1 <<< 22)) >>> 23;
      g = (q1 - q2 + (64'sd1 <<< 17)) >>> 18;
      if (m < -524288) m = -524288;
      if (m > 524287) m = 524287;
      if (g < -(64'sd1 <<< 25)) g = -(64'sd1 <<< 25);
      if (g > (64'sd1 <<< 25)) g = 64'sd1 <<< 25;
      pm[i] = m;
      sumsq += g * g;
    end
    t = int_sqrt(sumsq);
    gap = (t + 8) >> 4;
    if (gap > 1048575) gap = 1048575;
    res.mid_x = pm[0][PosW-1:0];
    res.mid_y = pm[1][PosW-1:0];
    res.mid_z = pm[2][PosW-1:0];
    res.gap   = gap[GapW-1:0];
    res.par   = (det == 0);
    return res;
  endfunction

  function automatic ray_pair_t make_rays(int d1x, int d1y, int d1z, int p1x, int p1y,
                                          int p1z, int d2x, int d2y, int d2z, int p2x,
                                          int p2y, int p2z);
    ray_pair_t r;
    r.d1[0] = DirW'(d1x); r.d1[1] = DirW'(d1y); r.d1[2] = DirW'(d1z);
    r.p1[0] = PosW'(p1x); r.p1[1] = PosW'(p1y); r.p1[2] = PosW'(p1z);
    r.d2[0] = DirW'(d2x); r.d2[1] = DirW'(d2y); r.d2[2] = DirW'(d2z);
    r.p2[0] = PosW'(p2x); r.p2[1] = PosW'(p2y); r.p2[2] = PosW'(p2z);
    return r;
  endfunction

  function automatic int rand_pos(bit near);
    if (near) return $urandom_range(8000) - 4000;
    return $signed($urandom_range(20'hfffff) << 12) >>> 12;
  endfunction

  function automatic int rand_dir(int mode);
    case (mode)
      0: return $signed(16'($urandom()));
      1: return $urandom_range(32768) - 16384;
      default: return $urandom_range(64) - 32;
    endcase
  endfunction

  function automatic ray_pair_t rand_rays();
    ray_pair_t r;
    int        mode, k;
    bit        near;
    mode = $urandom_range(9);
    near = $urandom_range(1);
    for (int i = 0; i < 3; i++) begin
      r.d1[i] = DirW'(rand_dir(mode < 3 ? 0 : (mode < 8 ? 1 : 2)));
      r.d2[i] = DirW'(rand_dir(mode < 3 ? 0 : (mode < 8 ? 1 : 2)));
      r.p1[i] = PosW'(rand_pos(near));
      r.p2[i] = PosW'(rand_pos(near));
    end
    k = $urandom_range(7);
    // parallel, anti-parallel and nearly parallel pairs, and sometimes a zero first direction
    if (k == 0) for (int i = 0; i < 3; i++) r.d2[i] = r.d1[i];
    if (k == 1) for (int i = 0; i < 3; i++) r.d2[i] = -(r.d1[i] >>> 1);
    if (k == 2) begin
      for (int i = 0; i < 3; i++) r.d2[i] = r.d1[i];
      r.d2[$urandom_range(2)] += DirW'($urandom_range(4) - 2);
    end
    if (k == 3 && $urandom_range(3) == 0)
      for (int i = 0; i < 3; i++) r.d1[i] = '0;
    return r;
  endfunction

  task automatic send_rays(ray_pair_t r, bit known, midpoint_t exp_res);
    if (!calm && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_rays(r);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_midpoints.push_back(known ? exp_res : triangulate(r));
  endtask

  // output stall bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    midpoint_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[PosW-1:0], m_axis_tdata[2*PosW-1:PosW],
             m_axis_tdata[3*PosW-1:2*PosW], m_axis_tdata[4*PosW-1:3*PosW],
             m_axis_tuser[0]};
      if (pending_midpoints.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", got);
      end else begin
        want = pending_midpoints.pop_front();
        if (got.mid_x !== want.mid_x || got.mid_y !== want.mid_y ||
            got.mid_z !== want.mid_z || got.gap !== want.gap || got.par !== want.par) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp mid %0d %0d %0d gap %0d par %0d, got %0d %0d %0d %0d %0d",
                     $signed(want.mid_x), $signed(want.mid_y), $signed(want.mid_z),
                     want.gap, want.par, $signed(got.mid_x), $signed(got.mid_y),
                     $signed(got.mid_z), got.gap, got.par);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    row_t table_rows[$];
    row_t row;
    int   wait_cycles;
    // directed rows; zero directions give the two origins
    row.known = 1;
    row.rays = make_rays(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = '{0, 0, 0, 0, 1};
    table_rows.push_back(row);
    row.rays = make_rays(0, 0, 0, 16, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = '{8, 0, 0, 16, 1};
    table_rows.push_back(row);
    row.rays = make_rays(0, 0, 0, 524287, 524287, 524287, 0, 0, 0,
                         -524288, -524288, -524288);
    row.res = '{0, 0, 0, 20'hfffff, 1};
    table_rows.push_back(row);
    row.known = 0;
    row.rays = make_rays(16384, 0, 0, 0, 0, 160, 0, 16384, 0, 0, 0, 0);
    table_rows.push_back(row);
    row.rays = make_rays(16384, 0, 0, 100, 50, 1600, 0, 0, 16384, -30, 400, -2);
    table_rows.push_back(row);
    row.rays = make_rays(32767, 32767, 32767, 524287, -524288, 0,
                         -32768, -32768, 32767, -524288, 524287, 0);
    table_rows.push_back(row);
    row.rays = make_rays(-32768, -32768, -32768, 1, -1, 524287,
                         -32768, -32768, -32768, 0, 0, -524288);
    table_rows.push_back(row);
    row.rays = make_rays(-32768, 0, 0, 0, 0, 0, 32767, 0, 0, 5000, 5000, 0);
    table_rows.push_back(row);
    row.rays = make_rays(16384, 1, 0, -524288, 0, 0, 16384, 0, 0, 524287, 9000, 0);
    table_rows.push_back(row);
    row.rays = make_rays(16384, 16384, 0, 0, 0, 0, 16383, 16385, 0, 524287, -524288, 100);
    table_rows.push_back(row);
    row.rays = make_rays(3, 2, 1, 12345, -6789, 222, -1, 3, 2, -5000, 40000, -7);
    table_rows.push_back(row);
    row.rays = make_rays(11585, 11585, 0, 0, 0, 0, 11585, -11585, 0, 800, 0, 3200);
    table_rows.push_back(row);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[i]) send_rays(table_rows[i].rays, table_rows[i].known,
                                      table_rows[i].res);
    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_midpoints.size() == 0);
        @(posedge clk_i);
      end
      if (n == 650) calm = 1'b1;
      send_rays(rand_rays(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_midpoints.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && pending_midpoints.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> two_ray_midpoint_top.f
hdl/trm_pkg.sv
hdl/two_ray_midpoint_top.sv
hdl/trm_checker.sv
verif/two_ray_midpoint_top_tb.sv
